// ===== design/lsd_pkg.sv =====
// package: register indexes and pipeline sideband types for the limited-slip split
package lsd_pkg;

    localparam logic [7:0] REG_GEAR_RATIO = 8'd0;
    localparam logic [7:0] REG_DRIVE_LOCK = 8'd1;
    localparam logic [7:0] REG_COAST_LOCK = 8'd2;
    localparam logic [7:0] REG_PRELOAD    = 8'd3;

    localparam logic [16:0] LOCK_ONE = 17'd65536;

    // carried alongside the reduced-inertia divider
    typedef struct packed {
        logic signed [39:0] open_tq;
        logic [40:0]        cap;
        logic               diff_pos;
        logic               diff_neg;
        logic [32:0]        abs_diff;
        logic [31:0]        share;
        logic [23:0]        step_time;
        logic               den_zero;
    } div1_side_t;

    // carried alongside the no-overshoot divider
    typedef struct packed {
        logic signed [39:0] open_tq;
        logic [40:0]        cap;
        logic               diff_pos;
        logic               diff_neg;
        logic [31:0]        share;
        logic               big;
        logic               dt_zero;
    } div2_side_t;

endpackage

// ===== design/lsd_if.sv =====
// interfaces: input item, result item and configuration write channels
interface lsd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_torque;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic [31:0]        left_inertia;
    logic [31:0]        right_inertia;
    logic [23:0]        step_time;
    logic [31:0]        upstream_inertia;
    modport source (output valid, drive_torque, left_speed, right_speed, left_inertia,
                    right_inertia, step_time, upstream_inertia, input ready);
    modport sink (input valid, drive_torque, left_speed, right_speed, left_inertia,
                  right_inertia, step_time, upstream_inertia, output ready);
endinterface

interface lsd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_torque;
    logic signed [31:0] right_torque;
    logic [31:0]        wheel_inertia_share;
    modport source (output valid, left_torque, right_torque, wheel_inertia_share,
                    input ready);
    modport sink (input valid, left_torque, right_torque, wheel_inertia_share,
                  output ready);
endinterface

interface lsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/lsd_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
module lsd_divider #(
    parameter int QW = 32,
    parameter int DW = 33,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] num_hi,
    input  logic [QW-1:0] num_lo,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] side_out
);

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] lo_reg   [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [QW-1:0] valid_reg;

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0] rem_prev;
        logic [QW-1:0] lo_prev;
        logic [DW-1:0] den_prev;
        logic [SW-1:0] side_prev;
        logic          valid_prev;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] lo_next;

        if (k == 0) begin : g_first
            assign rem_prev   = num_hi;
            assign lo_prev    = num_lo;
            assign den_prev   = den;
            assign side_prev  = side_in;
            assign valid_prev = in_valid;
        end
        else begin : g_rest
            assign rem_prev   = rem_reg[k-1];
            assign lo_prev    = lo_reg[k-1];
            assign den_prev   = den_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        // dividend bits shift out of the top while quotient bits shift in below
        assign trial    = {rem_prev, lo_prev[QW-1]};
        assign ge       = trial >= {1'b0, den_prev};
        assign diff     = trial - {1'b0, den_prev};
        assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign lo_next  = {lo_prev[QW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                lo_reg[k]   <= lo_next;
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quot      = lo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

// ===== design/limited_slip_diff_torque_split_top.sv =====
// top level: clutch-pack limited-slip differential torque split pipeline
//
//  channel  dir  handshake      payload
//  cfg      in   valid/ready    index[7:0], data[31:0]
//  item     in   valid/ready    torque, speeds, inertias, step time, upstream inertia
//  result   out  valid/ready    left and right torque, wheel inertia share
//
// one transaction per cycle sustained while the result side keeps the pipeline enabled
// the pipeline holds two bit-serial dividers: 32 stages for the reduced
// inertia and 41 for the no-overshoot cap, plus four arithmetic stages
// one enable moves the whole pipeline; it holds only while a result waits
// reset clears the valid bits and loads the register reset values
module limited_slip_diff_torque_split_top (
    input  logic      clk,
    input  logic      rst_n,
    lsd_cfg_if.sink   cfg,
    lsd_in_if.sink    item,
    lsd_out_if.source result
);

    localparam int D1_SW = $bits(lsd_pkg::div1_side_t);
    localparam int D2_SW = $bits(lsd_pkg::div2_side_t);

    function automatic logic signed [31:0] sat_s32(input logic signed [42:0] v);
        logic signed [31:0] r;
        if (v > 43'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -43'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // configuration
    logic [23:0] gear_ratio_reg;
    logic [16:0] drive_lock_reg;
    logic [16:0] coast_lock_reg;
    logic [30:0] preload_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_ratio_reg <= 24'd65536;
            drive_lock_reg <= 17'd0;
            coast_lock_reg <= 17'd0;
            preload_reg    <= 31'd0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                lsd_pkg::REG_GEAR_RATIO: gear_ratio_reg <= cfg.data[23:0];
                lsd_pkg::REG_DRIVE_LOCK: drive_lock_reg <= cfg.data[16:0];
                lsd_pkg::REG_COAST_LOCK: coast_lock_reg <= cfg.data[16:0];
                lsd_pkg::REG_PRELOAD:    preload_reg    <= cfg.data[30:0];
                default: ;
            endcase
        end
    end

    logic out_valid_reg;
    logic en;

    assign en         = !out_valid_reg || result.ready;
    assign item.ready = en;

    // stage 1: products, sums, differences
    logic               v1_reg;
    logic signed [56:0] geared_reg;
    logic [63:0]        prod_reg;
    logic [32:0]        den_reg;
    logic signed [32:0] diff_reg;
    logic               ssum_neg_reg;
    logic               ssum_zero_reg;
    logic [55:0]        a_reg;
    logic [23:0]        dt1_reg;

    logic signed [56:0] geared_next;
    logic signed [32:0] ssum_next;

    assign geared_next = $signed({1'b0, gear_ratio_reg}) * item.drive_torque;
    assign ssum_next   = 33'(item.left_speed) + 33'(item.right_speed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geared_reg    <= geared_next;
            prod_reg      <= 64'(item.left_inertia) * 64'(item.right_inertia);
            den_reg       <= 33'(item.left_inertia) + 33'(item.right_inertia);
            diff_reg      <= 33'(item.left_speed) - 33'(item.right_speed);
            ssum_neg_reg  <= ssum_next[32];
            ssum_zero_reg <= ssum_next == 33'sd0;
            a_reg         <= 56'(item.upstream_inertia) * 56'(gear_ratio_reg);
            dt1_reg       <= item.step_time;
        end
    end

    // stage 2: open share, lock ratio, capacity, inertia share
    logic                v2_reg;
    logic [63:0]         prod2_reg;
    logic [32:0]         den2_reg;
    lsd_pkg::div1_side_t side1_reg;

    logic                g_zero;
    logic                drive;
    logic [16:0]         lock_sel;
    logic [16:0]         lock;
    logic [55:0]         abs_g;
    logic [56:0]         capm;
    logic [63:0]         b_prod;
    logic [46:0]         share_wide;
    lsd_pkg::div1_side_t side1_next;

    always_comb
    begin
        g_zero   = geared_reg == 57'sd0;
        drive    = g_zero || ssum_zero_reg || (geared_reg[56] == ssum_neg_reg);
        lock_sel = drive ? drive_lock_reg : coast_lock_reg;
        lock     = (lock_sel > lsd_pkg::LOCK_ONE) ? lsd_pkg::LOCK_ONE : lock_sel;
        abs_g    = geared_reg[56] ? 56'(-geared_reg) : geared_reg[55:0];
        capm     = 57'(lock) * 57'(abs_g[55:16]);
        b_prod   = 64'(a_reg[55:16]) * 64'(gear_ratio_reg);
        share_wide = b_prod[63:17];

        side1_next.open_tq   = geared_reg[56:17];
        side1_next.cap       = 41'(preload_reg) + capm[56:16];
        side1_next.diff_pos  = !diff_reg[32] && (diff_reg != 33'sd0);
        side1_next.diff_neg  = diff_reg[32];
        side1_next.abs_diff  = diff_reg[32] ? 33'(-diff_reg) : diff_reg;
        side1_next.share     = (share_wide[46:32] != 15'd0) ? 32'hFFFFFFFF
                                                            : share_wide[31:0];
        side1_next.step_time = dt1_reg;
        side1_next.den_zero  = den_reg == 33'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod2_reg <= prod_reg;
            den2_reg  <= den_reg;
            side1_reg <= side1_next;
        end
    end

    // reduced inertia: Il*Ir / (Il+Ir)
    logic                d1_valid;
    logic [31:0]         d1_quot;
    logic [D1_SW-1:0]    d1_side_bits;
    lsd_pkg::div1_side_t d1_side;

    lsd_divider #(
        .QW(32),
        .DW(33),
        .SW(D1_SW)
    ) u_div_red (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v2_reg),
        .num_hi   ({1'b0, prod2_reg[63:32]}),
        .num_lo   (prod2_reg[31:0]),
        .den      (den2_reg),
        .side_in  (side1_reg),
        .out_valid(d1_valid),
        .quot     (d1_quot),
        .side_out (d1_side_bits)
    );

    assign d1_side = lsd_pkg::div1_side_t'(d1_side_bits);

    // stage m: reduced inertia times speed difference
    logic        vm_reg;
    logic [63:0] x_reg;
    logic [23:0] dtm_reg;
    lsd_pkg::div2_side_t sidem_reg;

    logic [31:0] red;
    logic [64:0] x_wide;

    assign red    = d1_side.den_zero ? 32'd0 : d1_quot;
    assign x_wide = 65'(red) * 65'(d1_side.abs_diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg              <= x_wide[63:0];
            dtm_reg            <= d1_side.step_time;
            sidem_reg.open_tq  <= d1_side.open_tq;
            sidem_reg.cap      <= d1_side.cap;
            sidem_reg.diff_pos <= d1_side.diff_pos;
            sidem_reg.diff_neg <= d1_side.diff_neg;
            sidem_reg.share    <= d1_side.share;
            sidem_reg.big      <= 1'b0;
            sidem_reg.dt_zero  <= d1_side.step_time == 24'd0;
        end
    end

    // no-overshoot cap: x * 2^8 / dt, quotient kept to 41 bits
    lsd_pkg::div2_side_t side2_in;
    logic                d2_valid;
    logic [40:0]         d2_quot;
    logic [D2_SW-1:0]    d2_side_bits;
    lsd_pkg::div2_side_t d2_side;

    always_comb
    begin
        side2_in     = sidem_reg;
        // quotient of 2^41 or more always exceeds the capacity
        side2_in.big = x_reg[63:33] >= 31'(dtm_reg);
    end

    lsd_divider #(
        .QW(41),
        .DW(24),
        .SW(D2_SW)
    ) u_div_nov (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (vm_reg),
        .num_hi   (x_reg[56:33]),
        .num_lo   ({x_reg[32:0], 8'd0}),
        .den      (dtm_reg),
        .side_in  (side2_in),
        .out_valid(d2_valid),
        .quot     (d2_quot),
        .side_out (d2_side_bits)
    );

    assign d2_side = lsd_pkg::div2_side_t'(d2_side_bits);

    // output stage: transfer and saturation
    logic signed [31:0] left_reg;
    logic signed [31:0] right_reg;
    logic [31:0]        share_reg;

    logic [40:0]        mag;
    logic signed [42:0] transfer;
    logic signed [42:0] open_ext;

    always_comb
    begin
        if (d2_side.dt_zero)
            mag = 41'd0;
        else if (d2_side.big || (d2_quot > d2_side.cap))
            mag = d2_side.cap;
        else
            mag = d2_quot;
        priority if (d2_side.diff_pos)
            transfer = $signed({2'b00, mag});
        else if (d2_side.diff_neg)
            transfer = -$signed({2'b00, mag});
        else
            transfer = 43'sd0;
        open_ext = 43'(d2_side.open_tq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg  <= sat_s32(open_ext - transfer);
            right_reg <= sat_s32(open_ext + transfer);
            share_reg <= d2_side.share;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.left_torque         = left_reg;
    assign result.right_torque        = right_reg;
    assign result.wheel_inertia_share = share_reg;

endmodule

// ===== sim/tb_lsd_if_note.sv =====
`timescale 1ns / 1ps
// helper package: torque split predictor types shared by the bench
package tb_lsd_pkg;

    typedef struct {
        logic signed [31:0] left_torque;
        logic signed [31:0] right_torque;
        logic [31:0]        wheel_inertia_share;
    } split_t;

    typedef struct {
        logic signed [31:0] drive_torque;
        logic signed [31:0] left_speed;
        logic signed [31:0] right_speed;
        logic [31:0]        left_inertia;
        logic [31:0]        right_inertia;
        logic [23:0]        step_time;
        logic [31:0]        upstream_inertia;
    } wheel_item_t;

endpackage

// ===== sim/tb_limited_slip_diff_torque_split_top.sv =====
`timescale 1ns / 1ps
// testbench: limited-slip torque split checked against a bit-true predictor
module tb_limited_slip_diff_torque_split_top;

    localparam int LATENCY = 77;

    logic clk;
    logic rst_n;

    lsd_cfg_if cfg ();
    lsd_in_if  item ();
    lsd_out_if result ();

    limited_slip_diff_torque_split_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.sink),
        .item   (item.sink),
        .result (result.source)
    );

    // register shadow
    logic [23:0] ratio_q;
    logic [16:0] drive_lock_q;
    logic [16:0] coast_lock_q;
    logic [30:0] preload_q;

    tb_lsd_pkg::split_t expected_splits[$];
    int     errors;
    int     hold_off;
    bit     stimulus_done;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #50ms;
        $display("** limited_slip_diff_torque_split_top: FAILED **");
        $finish;
    end

    function automatic tb_lsd_pkg::split_t predict_split(tb_lsd_pkg::wheel_item_t w);
        tb_lsd_pkg::split_t s;
        logic signed [63:0] geared;
        logic signed [63:0] open_tq;
        logic signed [63:0] ssum;
        logic signed [63:0] diff;
        logic signed [63:0] transfer;
        logic signed [63:0] v;
        logic [63:0] lock;
        logic [63:0] abs_g;
        logic [63:0] cap;
        logic [63:0] den;
        logic [63:0] red;
        logic [63:0] abs_d;
        logic [63:0] nov;
        logic [63:0] x;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] mag;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] share;
        bit drive;
        geared = $signed({40'd0, ratio_q}) * 64'(w.drive_torque);
        open_tq = geared >>> 17;
        ssum = 64'(w.left_speed) + 64'(w.right_speed);
        drive = (geared == 0) || (ssum == 0) || ((geared < 0) == (ssum < 0));
        lock = drive ? 64'(drive_lock_q) : 64'(coast_lock_q);
        if (lock > 64'(lsd_pkg::LOCK_ONE))
            lock = 64'(lsd_pkg::LOCK_ONE);
        abs_g = geared < 0 ? 64'(-geared) : 64'(geared);
        cap = 64'(preload_q) + ((lock * (abs_g >> 16)) >> 16);
        den = 64'(w.left_inertia) + 64'(w.right_inertia);
        red = den != 0 ? (64'(w.left_inertia) * 64'(w.right_inertia)) / den : 64'd0;
        diff = 64'(w.left_speed) - 64'(w.right_speed);
        abs_d = diff < 0 ? 64'(-diff) : 64'(diff);
        nov = 64'd0;
        if (w.step_time != 0)
        begin
            x = red * abs_d;
            q = x / 64'(w.step_time);
            r = x % 64'(w.step_time);
            if (q >= (64'd1 << 48))
                nov = '1;
            else
                nov = (q << 8) + ((r << 8) / 64'(w.step_time));
        end
        mag = cap < nov ? cap : nov;
        transfer = diff > 0 ? $signed(mag) : (diff < 0 ? -$signed(mag) : 64'sd0);
        a = 64'(w.upstream_inertia) * 64'(ratio_q);
        b = (a >> 16) * 64'(ratio_q);
        share = b >> 17;
        s.wheel_inertia_share = share > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : share[31:0];
        v = open_tq - transfer;
        s.left_torque = v > 64'sh7FFF_FFFF ? 32'sh7FFF_FFFF
                      : (v < -64'sh8000_0000 ? 32'sh8000_0000 : v[31:0]);
        v = open_tq + transfer;
        s.right_torque = v > 64'sh7FFF_FFFF ? 32'sh7FFF_FFFF
                       : (v < -64'sh8000_0000 ? 32'sh8000_0000 : v[31:0]);
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] value);
        cfg.index <= idx;
        cfg.data  <= value;
        cfg.valid <= 1'b1;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        unique case (idx)
            lsd_pkg::REG_GEAR_RATIO: ratio_q      = value[23:0];
            lsd_pkg::REG_DRIVE_LOCK: drive_lock_q = value[16:0];
            lsd_pkg::REG_COAST_LOCK: coast_lock_q = value[16:0];
            lsd_pkg::REG_PRELOAD:    preload_q    = value[30:0];
            default: ;
        endcase
    endtask

    task automatic drain_results();
        item.valid <= 1'b0;
        while (expected_splits.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    // sends one transaction; a known split overrides the predictor
    task automatic send_item(tb_lsd_pkg::wheel_item_t w, bit known, tb_lsd_pkg::split_t want,
                             bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 19);
        if (gap > 0 && $urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.drive_torque     <= w.drive_torque;
        item.left_speed       <= w.left_speed;
        item.right_speed      <= w.right_speed;
        item.left_inertia     <= w.left_inertia;
        item.right_inertia    <= w.right_inertia;
        item.step_time        <= w.step_time;
        item.upstream_inertia <= w.upstream_inertia;
        item.valid            <= 1'b1;
        do @(posedge clk); while (!item.ready);
        expected_splits.push_back(known ? want : predict_split(w));
        @(negedge clk);
    endtask

    function automatic tb_lsd_pkg::wheel_item_t random_item(int flavour);
        tb_lsd_pkg::wheel_item_t w;
        w.drive_torque     = $urandom;
        w.left_speed       = $urandom;
        w.right_speed      = $urandom;
        w.left_inertia     = $urandom;
        w.right_inertia    = $urandom;
        w.step_time        = 24'($urandom);
        w.upstream_inertia = $urandom;
        case (flavour)
            // realistic magnitudes so neither cap dominates every time
            0:
            begin
                w.drive_torque  = $signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
                w.left_speed    = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
                w.right_speed   = w.left_speed + $signed($urandom_range(0, 32'h3_FFFF))
                                - 32'sh2_0000;
                w.left_inertia  = $urandom_range(0, 32'h00FF_FFFF);
                w.right_inertia = $urandom_range(0, 32'h00FF_FFFF);
                w.step_time     = 24'($urandom_range(1, 24'h08_0000));
                w.upstream_inertia = $urandom_range(0, 32'h00FF_FFFF);
            end
            1: w.right_speed = w.left_speed;
            2: w.step_time = 24'd0;
            3:
            begin
                w.left_inertia  = 32'd0;
                w.right_inertia = 32'd0;
            end
            default: ;
        endcase
        return w;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        tb_lsd_pkg::split_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_splits.size() == 0)
            begin
                $display("unexpected result transaction");
                errors++;
            end
            else
            begin
                want = expected_splits.pop_front();
                if (result.left_torque !== want.left_torque)
                    report_mismatch("left_torque", result.left_torque, want.left_torque);
                if (result.right_torque !== want.right_torque)
                    report_mismatch("right_torque", result.right_torque, want.right_torque);
                if (result.wheel_inertia_share !== want.wheel_inertia_share)
                    report_mismatch("wheel_inertia_share", result.wheel_inertia_share,
                                    want.wheel_inertia_share);
            end
        end
    end

    // result back-pressure: random stalls, one long hold-off when asked
    initial
    begin
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                result.ready <= 1'b0;
                repeat (hold_off) @(negedge clk);
                hold_off = 0;
            end
            stall = $urandom_range(0, 19);
            if (stimulus_done || $urandom_range(0, 2) == 0)
                stall = 0;
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                result.ready <= 1'b1;
        end
    end

    typedef struct {
        tb_lsd_pkg::wheel_item_t w;
        bit                      known;
        tb_lsd_pkg::split_t      want;
    } directed_row_t;

    initial
    begin
        directed_row_t           rows[$];
        directed_row_t           row;
        tb_lsd_pkg::wheel_item_t w;
        tb_lsd_pkg::split_t      none;
        int                      n;
        none = '{32'sd0, 32'sd0, 32'd0};
        errors = 0;
        hold_off = 0;
        stimulus_done = 0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = lsd_pkg::REG_GEAR_RATIO;
        cfg.data = 32'd0;
        item.valid = 1'b0;
        item.drive_torque = '0;
        item.left_speed = '0;
        item.right_speed = '0;
        item.left_inertia = '0;
        item.right_inertia = '0;
        item.step_time = '0;
        item.upstream_inertia = '0;
        ratio_q = 24'd65536;
        drive_lock_q = '0;
        coast_lock_q = '0;
        preload_q = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: after reset ratio is one, no lock, no preload
        row.known = 1;
        row.w = '{32'sd0, 32'sd0, 32'sd0, 32'd0, 32'd0, 24'd0, 32'd0};
        row.want = none;
        rows.push_back(row);
        row.w = '{32'sh0002_0000, 32'sd0, 32'sd0, 32'd0, 32'd0, 24'd0, 32'h0002_0000};
        row.want = '{32'sh0001_0000, 32'sh0001_0000, 32'h0001_0000};
        rows.push_back(row);
        row.w = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF};
        row.want = '{32'sh3FFF_FFFF, 32'sh3FFF_FFFF, 32'h7FFF_FFFF};
        rows.push_back(row);
        row.w = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'd0, 32'd0,
                  24'd1, 32'd0};
        row.want = '{32'shC000_0000, 32'shC000_0000, 32'd0};
        rows.push_back(row);
        foreach (rows[i])
            send_item(rows[i].w, rows[i].known, rows[i].want, 0);
        drain_results();

        // full lock, big preload, max ratio: saturation and transfer paths
        write_reg(lsd_pkg::REG_GEAR_RATIO, 32'h00FF_FFFF);
        write_reg(lsd_pkg::REG_DRIVE_LOCK, 32'h0001_FFFF);
        write_reg(lsd_pkg::REG_COAST_LOCK, 32'd65536);
        write_reg(lsd_pkg::REG_PRELOAD, 32'h7FFF_FFFF);
        write_reg(8'd200, 32'h1234_5678);
        for (int i = 0; i < 6; i++)
            send_item(random_item(i % 4), 0, none, 0);
        w = '{32'sh7FFF_FFFF, 32'sh0100_0000, 32'sd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              24'd1, 32'hFFFF_FFFF};
        send_item(w, 0, none, 0);
        w.drive_torque = 32'sh8000_0000;
        send_item(w, 0, none, 0);
        drain_results();

        // random phases over several register settings
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase > 0)
            begin
                write_reg(lsd_pkg::REG_GEAR_RATIO,
                          phase == 5 ? 32'd0 : $urandom_range(0, 24'h04_0000));
                write_reg(lsd_pkg::REG_DRIVE_LOCK, $urandom_range(0, 17'h1_FFFF));
                write_reg(lsd_pkg::REG_COAST_LOCK,
                          phase == 5 ? 32'd0 : $urandom_range(0, 65536));
                write_reg(lsd_pkg::REG_PRELOAD, $urandom_range(0, 32'h00FF_FFFF));
            end
            if (phase == 2)
                hold_off = 200;
            n = 230;
            for (int i = 0; i < n; i++)
                send_item(random_item($urandom_range(0, 5) == 0 ? 4 : $urandom_range(0, 3)),
                          0, none, phase == 2 && i < 150);
            item.valid <= 1'b0;
            // sender pause until everything is back
            drain_results();
        end
        stimulus_done = 1;
        item.valid <= 1'b0;
        drain_results();
        if (errors == 0)
            $display("** limited_slip_diff_torque_split_top: PASSED **");
        else
            $display("** limited_slip_diff_torque_split_top: FAILED **");
        $finish;
    end

endmodule

// ===== limited_slip_diff_torque_split_top.f =====
design/lsd_pkg.sv
design/lsd_if.sv
design/lsd_divider.sv
design/limited_slip_diff_torque_split_top.sv
sim/tb_lsd_if_note.sv
sim/tb_limited_slip_diff_torque_split_top.sv
